/* rtl/rbsm_pkg.sv */
// Shared types and constants for the ring buffer space manager.
`default_nettype none

package rbsm_pkg;

   localparam int CMD_W    = 3;
   localparam int SIZE_W   = 17;
   localparam int IDX_W    = 17;
   localparam int OFF_W    = 16;
   localparam int ST_W     = 3;
   localparam int LOG2_W   = 5;

   localparam int MAX_CAPACITY_LOG2_DEF = 16;
   localparam logic [LOG2_W-1:0] CAP_LOG2_RESET = LOG2_W'(16);
   localparam logic [LOG2_W-1:0] CAP_LOG2_MIN   = LOG2_W'(2);

   typedef enum logic [CMD_W-1:0] {
      CMD_RESERVE    = 3'd0,
      CMD_COMMIT     = 3'd1,
      CMD_WRITE      = 3'd2,
      CMD_READ_BEGIN = 3'd3,
      CMD_READ_END   = 3'd4,
      CMD_CONSUME    = 3'd5
   } cmd_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK           = 3'd0,
      ST_BAD_SIZE     = 3'd1,
      ST_FULL         = 3'd2,
      ST_EMPTY        = 3'd3,
      ST_TOO_LARGE    = 3'd4,
      ST_OUT_OF_ORDER = 3'd5
   } status_type;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [SIZE_W-1:0] size;
      logic [IDX_W-1:0]  reserve_index;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [IDX_W-1:0]  start_index;
      logic [OFF_W-1:0]  data_offset;
      logic [OFF_W-1:0]  padding_offset;
      logic [SIZE_W-1:0] padding_size;
      logic [SIZE_W-1:0] chunk_size;
   } rsp_type;

endpackage

`default_nettype wire

/* rtl/ring_buffer_space_manager_unit.sv */
// Top level of the reserve/commit ring buffer space manager.
//
// Pointer bookkeeping for a power-of-two byte ring; the bytes themselves live in an
// external memory. A command is taken on any clock edge with start high (busy never
// rises), so one command per cycle is sustained. The edge that takes a command captures
// it; the next edge updates the pointers and registers the result, which then sits on the
// rsp_ ports with rsp_valid high for one cycle. The receiver cannot stall. Pointers are
// MAX_CAPACITY_LOG2+1 bits and free-running; csr_capacity_log2 is clamped to
// 2..MAX_CAPACITY_LOG2 and should only be changed with no command in flight (csr_ready is
// low while one is being processed).
`default_nettype none

module ring_buffer_space_manager_unit #(
   parameter int MAX_CAPACITY_LOG2 = rbsm_pkg::MAX_CAPACITY_LOG2_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic [rbsm_pkg::CMD_W-1:0]  req_command,
   input  wire logic [rbsm_pkg::SIZE_W-1:0] req_size,
   input  wire logic [rbsm_pkg::IDX_W-1:0]  req_reserve_index,
   output logic                             rsp_valid,
   output logic [rbsm_pkg::ST_W-1:0]        rsp_status,
   output logic [rbsm_pkg::IDX_W-1:0]       rsp_start_index,
   output logic [rbsm_pkg::OFF_W-1:0]       rsp_data_offset,
   output logic [rbsm_pkg::OFF_W-1:0]       rsp_padding_offset,
   output logic [rbsm_pkg::SIZE_W-1:0]      rsp_padding_size,
   output logic [rbsm_pkg::SIZE_W-1:0]      rsp_chunk_size,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [rbsm_pkg::LOG2_W-1:0] csr_capacity_log2
);

   logic                        req_valid_ff;
   rbsm_pkg::req_type           req_ff, req_in;
   logic [rbsm_pkg::LOG2_W-1:0] cap_log2_ff;
   rbsm_pkg::rsp_type           step_rsp, out_rsp;

   assign busy      = 1'b0;
   assign csr_ready = ~req_valid_ff;

   assign req_in.command       = req_command;
   assign req_in.size          = req_size;
   assign req_in.reserve_index = req_reserve_index;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         cap_log2_ff  <= rbsm_pkg::CAP_LOG2_RESET;
      end else begin
         req_valid_ff <= start;
         if (csr_valid && csr_ready) begin
            cap_log2_ff <= csr_capacity_log2;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         req_ff <= req_in;
      end
   end

   rbsm_ptr_unit #(
      .MAX_CAPACITY_LOG2(MAX_CAPACITY_LOG2)
   ) u_ptr (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid_ff),
      .req      (req_ff),
      .cap_log2 (cap_log2_ff),
      .rsp      (step_rsp)
   );

   rbsm_rsp_reg u_rsp (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_valid_ff),
      .in_rsp   (step_rsp),
      .rsp_valid(rsp_valid),
      .rsp      (out_rsp)
   );

   assign rsp_status         = out_rsp.status;
   assign rsp_start_index    = out_rsp.start_index;
   assign rsp_data_offset    = out_rsp.data_offset;
   assign rsp_padding_offset = out_rsp.padding_offset;
   assign rsp_padding_size   = out_rsp.padding_size;
   assign rsp_chunk_size     = out_rsp.chunk_size;

endmodule

`default_nettype wire

/* rtl/rbsm_ptr_unit.sv */
// Reserve, commit and read pointers with the per-command checks and updates.
`default_nettype none

module rbsm_ptr_unit #(
   parameter int MAX_CAPACITY_LOG2 = rbsm_pkg::MAX_CAPACITY_LOG2_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   input  wire rbsm_pkg::req_type           req,
   input  wire logic [rbsm_pkg::LOG2_W-1:0] cap_log2,
   output rbsm_pkg::rsp_type                rsp
);

   localparam int PW = MAX_CAPACITY_LOG2 + 1;
   localparam int EW = ((PW > rbsm_pkg::SIZE_W) ? PW : rbsm_pkg::SIZE_W) + 2;

   logic [PW-1:0] reserve_ptr_ff, reserve_ptr_in;
   logic [PW-1:0] committed_ptr_ff, committed_ptr_in;
   logic [PW-1:0] read_ptr_ff, read_ptr_in;

   logic [rbsm_pkg::LOG2_W-1:0] lg;
   logic [EW-1:0] cap_e, cmask, size_e;
   logic [EW-1:0] res_off, res_space, rsz, wr_used, wr_chunk;
   logic [EW-1:0] rd_off, rd_space, held, rd_chunk;
   logic          bad, wrap, res_full, wr_full;
   logic [PW-1:0] ridx, size_p;

   always_comb begin
      if (cap_log2 < rbsm_pkg::CAP_LOG2_MIN) begin
         lg = rbsm_pkg::CAP_LOG2_MIN;
      end else if (cap_log2 > rbsm_pkg::LOG2_W'(MAX_CAPACITY_LOG2)) begin
         lg = rbsm_pkg::LOG2_W'(MAX_CAPACITY_LOG2);
      end else begin
         lg = cap_log2;
      end
   end

   assign cap_e  = EW'(1) << lg;
   assign cmask  = cap_e - EW'(1);
   assign size_e = EW'(req.size);
   assign bad    = (req.size == '0) || (size_e > cap_e);

   // writer side: a reservation that does not fit before the ring end pads it out
   assign res_off   = EW'(reserve_ptr_ff) & cmask;
   assign res_space = cap_e - res_off;
   assign wrap      = size_e > res_space;
   assign rsz       = wrap ? (size_e + res_space) : size_e;
   assign wr_used   = EW'(PW'(reserve_ptr_ff - read_ptr_ff));
   assign res_full  = (wr_used + rsz) > cap_e;
   assign wr_full   = (wr_used + size_e) > cap_e;
   assign wr_chunk  = (size_e <= res_space) ? size_e : res_space;

   // reader side
   assign rd_off   = EW'(read_ptr_ff) & cmask;
   assign rd_space = cap_e - rd_off;
   assign held     = EW'(PW'(committed_ptr_ff - read_ptr_ff));
   assign rd_chunk = (size_e <= rd_space) ? size_e : rd_space;

   assign ridx   = PW'(req.reserve_index);
   assign size_p = PW'(req.size);

   always_comb begin
      reserve_ptr_in     = reserve_ptr_ff;
      committed_ptr_in   = committed_ptr_ff;
      read_ptr_in        = read_ptr_ff;
      rsp.status         = rbsm_pkg::ST_OK;
      rsp.start_index    = '0;
      rsp.data_offset    = '0;
      rsp.padding_offset = '0;
      rsp.padding_size   = '0;
      rsp.chunk_size     = '0;
      case (rbsm_pkg::cmd_type'(req.command))
         rbsm_pkg::CMD_RESERVE: begin
            rsp.start_index = rbsm_pkg::IDX_W'(reserve_ptr_ff);
            if (bad) begin
               rsp.status = rbsm_pkg::ST_BAD_SIZE;
            end else if (res_full) begin
               rsp.status = rbsm_pkg::ST_FULL;
            end else begin
               reserve_ptr_in = PW'(EW'(reserve_ptr_ff) + rsz);
               rsp.chunk_size = req.size;
               if (wrap) begin
                  rsp.padding_offset = rbsm_pkg::OFF_W'(res_off);
                  rsp.padding_size   = rbsm_pkg::SIZE_W'(res_space);
               end else begin
                  rsp.data_offset = rbsm_pkg::OFF_W'(res_off);
               end
            end
         end
         rbsm_pkg::CMD_COMMIT: begin
            rsp.start_index = rbsm_pkg::IDX_W'(committed_ptr_ff);
            if (ridx != committed_ptr_ff) begin
               rsp.status = rbsm_pkg::ST_OUT_OF_ORDER;
            end else begin
               committed_ptr_in = ridx + size_p;
            end
         end
         rbsm_pkg::CMD_WRITE: begin
            rsp.start_index = rbsm_pkg::IDX_W'(reserve_ptr_ff);
            if (bad) begin
               rsp.status = rbsm_pkg::ST_BAD_SIZE;
            end else if (wr_full) begin
               rsp.status = rbsm_pkg::ST_FULL;
            end else if (committed_ptr_ff != reserve_ptr_ff) begin
               rsp.status = rbsm_pkg::ST_OUT_OF_ORDER;
            end else begin
               reserve_ptr_in   = reserve_ptr_ff + size_p;
               committed_ptr_in = reserve_ptr_ff + size_p;
               rsp.data_offset  = rbsm_pkg::OFF_W'(res_off);
               rsp.chunk_size   = rbsm_pkg::SIZE_W'(wr_chunk);
            end
         end
         rbsm_pkg::CMD_READ_BEGIN: begin
            rsp.start_index = rbsm_pkg::IDX_W'(read_ptr_ff);
            if (bad) begin
               rsp.status = rbsm_pkg::ST_BAD_SIZE;
            end else if (committed_ptr_ff == read_ptr_ff) begin
               rsp.status = rbsm_pkg::ST_EMPTY;
            end else if (held < size_e) begin
               rsp.status = rbsm_pkg::ST_TOO_LARGE;
            end else begin
               rsp.data_offset = rbsm_pkg::OFF_W'(rd_off);
               rsp.chunk_size  = rbsm_pkg::SIZE_W'(rd_chunk);
            end
         end
         rbsm_pkg::CMD_READ_END: begin
            // unchecked advance
            rsp.start_index = rbsm_pkg::IDX_W'(read_ptr_ff);
            read_ptr_in     = read_ptr_ff + size_p;
         end
         rbsm_pkg::CMD_CONSUME: begin
            rsp.start_index = rbsm_pkg::IDX_W'(read_ptr_ff);
            if (bad) begin
               rsp.status = rbsm_pkg::ST_BAD_SIZE;
            end else if (committed_ptr_ff == read_ptr_ff) begin
               rsp.status = rbsm_pkg::ST_EMPTY;
            end else if (held < size_e) begin
               rsp.status = rbsm_pkg::ST_TOO_LARGE;
            end else begin
               read_ptr_in = read_ptr_ff + size_p;
            end
         end
         default: begin
            rsp.status = rbsm_pkg::ST_BAD_SIZE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reserve_ptr_ff   <= '0;
         committed_ptr_ff <= '0;
         read_ptr_ff      <= '0;
      end else if (req_valid) begin
         reserve_ptr_ff   <= reserve_ptr_in;
         committed_ptr_ff <= committed_ptr_in;
         read_ptr_ff      <= read_ptr_in;
      end
   end

   a_fail_holds_ptrs: assert property (@(posedge clock) disable iff (reset)
      (req_valid && rsp.status != rbsm_pkg::ST_OK) |=>
      ($stable(reserve_ptr_ff) && $stable(committed_ptr_ff) && $stable(read_ptr_ff)))
      else $error("pointer moved on a failed command");

   a_idle_holds_ptrs: assert property (@(posedge clock) disable iff (reset)
      !req_valid |=>
      ($stable(reserve_ptr_ff) && $stable(committed_ptr_ff) && $stable(read_ptr_ff)))
      else $error("pointer moved with no command");

   a_write_syncs: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req.command == rbsm_pkg::CMD_WRITE && rsp.status == rbsm_pkg::ST_OK)
      |=> (committed_ptr_ff == reserve_ptr_ff))
      else $error("write left committed and reserve pointers apart");

   a_wrap_at_zero: assert property (@(posedge clock) disable iff (reset)
      (req_valid && rsp.status == rbsm_pkg::ST_OK && rsp.padding_size != '0) |->
      (rsp.data_offset == '0 && req.command == rbsm_pkg::CMD_RESERVE))
      else $error("padded region does not restart at offset zero");

endmodule

`default_nettype wire

/* rtl/rbsm_rsp_reg.sv */
// Result register with its one-cycle strobe.
`default_nettype none

module rbsm_rsp_reg (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire rbsm_pkg::rsp_type in_rsp,
   output logic                   rsp_valid,
   output rbsm_pkg::rsp_type      rsp
);

   logic              rsp_valid_ff;
   rbsm_pkg::rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         rsp_ff <= in_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

`default_nettype wire
